### hw/rtl/vgsc_pkg.sv
// Shared types, constants and register indexes of the voxel grid sphere collision block.
// No dependencies; every other file imports this package.
package vgsc_pkg;

   localparam int GRID_X            = 64;
   localparam int GRID_Y            = 64;
   localparam int GRID_Z            = 32;
   localparam int MAX_RADIUS_VOXELS = 8;

   localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;
   localparam int CELL_W = $clog2(CELLS);
   localparam int X_W    = $clog2(GRID_X);
   localparam int Y_W    = $clog2(GRID_Y);
   localparam int Z_W    = $clog2(GRID_Z);
   localparam int C_W    = (X_W > Y_W) ? ((X_W > Z_W) ? X_W : Z_W) : ((Y_W > Z_W) ? Y_W : Z_W);

   localparam int EDGE_W = 25;
   localparam int INV_W  = 31;
   localparam int RV_W   = $clog2(MAX_RADIUS_VOXELS + 1);
   localparam int ACC_W  = EDGE_W + RV_W;
   localparam int DIFF_W = 33;
   localparam int PROD_W = DIFF_W + INV_W + 1;
   localparam int Q_W    = PROD_W - 32;
   localparam int IDX_W  = Q_W + 1;
   localparam int LIM_W  = IDX_W + 1;
   localparam int OFF_W  = (C_W + EDGE_W + 2 > DIFF_W + 1) ? C_W + EDGE_W + 2 : DIFF_W + 1;
   localparam int MAG_W  = 25;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int SUM_W  = SQ_W + 2;

   localparam logic [2:0] CSR_ORIGIN_X      = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_Y      = 3'd1;
   localparam logic [2:0] CSR_ORIGIN_Z      = 3'd2;
   localparam logic [2:0] CSR_VOXEL_EDGE    = 3'd3;
   localparam logic [2:0] CSR_INV_EDGE      = 3'd4;
   localparam logic [2:0] CSR_SPHERE_RADIUS = 3'd5;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_QUERY  = 1'b1;

   localparam logic [EDGE_W-1:0] VOXEL_EDGE_RESET = EDGE_W'(6554);
   localparam logic [INV_W-1:0]  INV_EDGE_RESET   = INV_W'(655360);

   typedef struct packed {
      logic               func;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
   } req_type;

   typedef struct packed {
      logic        collision;
      logic        outside_grid;
      logic [31:0] query_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic [EDGE_W-1:0]  voxel_edge;
      logic [INV_W-1:0]   inv_voxel_edge;
      logic [EDGE_W-1:0]  sphere_radius;
   } cfg_type;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [CELL_W-1:0] addr;
   } occ_req_type;

   typedef struct packed {
      logic valid;
      logic collision;
      logic outside_grid;
   } seq_res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_RND,
      ST_INSERT,
      ST_RADIUS,
      ST_BOUND,
      ST_OFFSET,
      ST_XROW,
      ST_YROW,
      ST_ZSCAN,
      ST_DRAIN,
      ST_DONE
   } seq_state_type;

endpackage

### hw/rtl/voxel_grid_sphere_collision.sv
// Top level of the voxel grid sphere collision block: register file, counter, result stage.
// Depends on vgsc_pkg, vgsc_occ_mem and vgsc_seq.
//
// The block holds a 64 x 64 x 32 one-bit occupancy grid in a single-port synchronous
// memory. After reset it sweeps the grid to free, one cell per cycle, and holds req_ready
// low meanwhile; register writes are taken during the sweep. An insert word (func 0)
// runs a multiply and a rounding step for each of the three axes, then one memory write.
// A query word (func 1) finds the radius rv in voxels, at most 8, then scans the in-grid
// voxels of the clipped cube of side 2*rv+1 through the one-read-per-cycle grid port. The
// scan stops early at the first voxel that hits. The result sits in an output register,
// so the next word is accepted while a result waits.
module voxel_grid_sphere_collision
   import vgsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   logic [31:0] query_cnt_ff, query_cnt_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   occ_req_type occ;
   logic        occ_rd_data;
   logic        clearing;
   logic        seq_idle;
   logic        take;
   logic        accept;
   seq_res_type res;

   // accept only when the sequencer is free and the grid is swept
   assign req_ready = seq_idle && !clearing;
   assign accept    = req_valid && req_ready;
   // the output slot frees when empty or when its word leaves this cycle
   assign take      = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X:      cfg_in.origin_x       = csr_wdata;
            CSR_ORIGIN_Y:      cfg_in.origin_y       = csr_wdata;
            CSR_ORIGIN_Z:      cfg_in.origin_z       = csr_wdata;
            CSR_VOXEL_EDGE:    cfg_in.voxel_edge     = csr_wdata[EDGE_W-1:0];
            CSR_INV_EDGE:      cfg_in.inv_voxel_edge = csr_wdata[INV_W-1:0];
            CSR_SPHERE_RADIUS: cfg_in.sphere_radius  = csr_wdata[EDGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      // count queries at acceptance; the result of a query includes itself
      query_cnt_in = query_cnt_ff;
      if (accept && req_data.func == FUNC_QUERY) begin
         query_cnt_in = query_cnt_ff + 32'd1;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (res.valid && take) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.collision    = res.collision;
         rsp_data_in.outside_grid = res.outside_grid;
         rsp_data_in.query_count  = query_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x       <= '0;
         cfg_ff.origin_y       <= '0;
         cfg_ff.origin_z       <= '0;
         cfg_ff.voxel_edge     <= VOXEL_EDGE_RESET;
         cfg_ff.inv_voxel_edge <= INV_EDGE_RESET;
         cfg_ff.sphere_radius  <= '0;
         query_cnt_ff          <= '0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         query_cnt_ff <= query_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   vgsc_occ_mem u_mem (
      .clock    (clock),
      .reset    (reset),
      .req      (occ),
      .rd_data  (occ_rd_data),
      .clearing (clearing)
   );

   vgsc_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (accept),
      .item        (req_data),
      .cfg         (cfg_ff),
      .take        (take),
      .occ_rd_data (occ_rd_data),
      .idle        (seq_idle),
      .occ         (occ),
      .res         (res)
   );

endmodule

### hw/rtl/vgsc_occ_mem.sv
// One-bit occupancy memory with a clearing sweep after reset.
// Depends on vgsc_pkg for the cell count and the access struct.
module vgsc_occ_mem
   import vgsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  occ_req_type req,
   output logic        rd_data,
   output logic        clearing
);

   logic              mem [CELLS];
   logic              clearing_ff, clearing_in;
   logic [CELL_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic              rd_data_ff;

   always_comb begin
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      if (clearing_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CELL_W'(CELLS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
      end
   end

   // sweep zeros first, then take obstacle marks
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem[clr_cnt_ff] <= 1'b0;
      end else if (req.wr_en) begin
         mem[req.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_data_ff <= mem[req.addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clearing_ff;

endmodule

### hw/rtl/vgsc_seq.sv
// Per-word sequencer: voxel index rounding, insert write, radius search and cube scan.
// Depends on vgsc_pkg; drives the occupancy memory port.
module vgsc_seq
   import vgsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  req_type     item,
   input  cfg_type     cfg,
   input  logic        take,
   input  logic        occ_rd_data,
   output logic        idle,
   output occ_req_type occ,
   output seq_res_type res
);

   seq_state_type state_ff, state_in;

   logic                     func_ff, func_in;
   logic signed [DIFF_W-1:0] diff_ff [3];
   logic signed [DIFF_W-1:0] diff_in [3];
   logic [1:0]               axis_ff, axis_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [IDX_W-1:0]  idx_ff [3];
   logic signed [IDX_W-1:0]  idx_in [3];
   logic [RV_W-1:0]          k_ff, k_in;
   logic [ACC_W-1:0]         acc_ff, acc_in;
   logic [SQ_W-1:0]          r2_ff, r2_in;
   logic [C_W-1:0]           lo_ff [3];
   logic [C_W-1:0]           lo_in [3];
   logic [C_W-1:0]           hi_ff [3];
   logic [C_W-1:0]           hi_in [3];
   logic [C_W-1:0]           cur_ff [3];
   logic [C_W-1:0]           cur_in [3];
   logic signed [OFF_W-1:0]  off_ff [3];
   logic signed [OFF_W-1:0]  off_in [3];
   logic signed [OFF_W-1:0]  off0_ff [3];
   logic signed [OFF_W-1:0]  off0_in [3];
   logic [SQ_W-1:0]          ax2_ff, ax2_in;
   logic [SQ_W-1:0]          ay2_ff, ay2_in;
   logic                     pv_ff, pv_in;
   logic [SUM_W-1:0]         psum_ff, psum_in;
   logic [SQ_W-1:0]          paz2_ff, paz2_in;
   logic                     coll_ff, coll_in;
   logic                     outside_ff, outside_in;

   // combinational helpers
   logic                     neg;
   logic [PROD_W-1:0]        mag_p, rnd_p;
   logic [Q_W-1:0]           q;
   logic signed [IDX_W-1:0]  idx_new;
   logic [OFF_W-1:0]         amag [3];
   logic                     ok [3];
   logic [MAG_W-1:0]         sq_op;
   logic [SQ_W-1:0]          sq;
   logic signed [LIM_W-1:0]  lo_s [3];
   logic signed [LIM_W-1:0]  hi_s [3];
   logic signed [LIM_W-1:0]  lo_c [3];
   logic signed [LIM_W-1:0]  hi_c [3];
   logic                     empty;
   logic                     in_grid;
   logic                     x_end, y_end, z_end;
   logic [OFF_W-1:0]         ve_ext;

   function automatic int grid_dim(input int a);
      int g;
      begin
         g = (a == 0) ? GRID_X : ((a == 1) ? GRID_Y : GRID_Z);
         return g;
      end
   endfunction

   function automatic logic [CELL_W-1:0] cell_addr(input logic [C_W-1:0] x,
                                                   input logic [C_W-1:0] y,
                                                   input logic [C_W-1:0] z);
      logic [CELL_W-1:0] a;
      begin
         a = CELL_W'(x) + CELL_W'(GRID_X) * (CELL_W'(y) + CELL_W'(GRID_Y) * CELL_W'(z));
         return a;
      end
   endfunction

   assign ve_ext  = OFF_W'(cfg.voxel_edge);
   assign prod_in = diff_ff[axis_ff] * $signed({1'b0, cfg.inv_voxel_edge});

   // round magnitude, ties away from zero
   always_comb begin
      neg     = prod_ff[PROD_W-1];
      mag_p   = neg ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      rnd_p   = mag_p + PROD_W'(64'h8000_0000);
      q       = rnd_p[PROD_W-1:32];
      idx_new = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
   end

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         amag[a] = off_ff[a][OFF_W-1] ? OFF_W'(-off_ff[a]) : OFF_W'(off_ff[a]);
         ok[a]   = (amag[a] < (OFF_W'(1) << MAG_W));
      end
      priority case (state_ff)
         ST_XROW: sq_op = amag[0][MAG_W-1:0];
         ST_YROW: sq_op = amag[1][MAG_W-1:0];
         default: sq_op = amag[2][MAG_W-1:0];
      endcase
      sq = sq_op * sq_op;
   end

   always_comb begin
      empty   = 1'b0;
      in_grid = 1'b1;
      for (int a = 0; a < 3; a++) begin
         lo_s[a] = LIM_W'(idx_ff[a]) - $signed(LIM_W'(k_ff));
         hi_s[a] = LIM_W'(idx_ff[a]) + $signed(LIM_W'(k_ff));
         lo_c[a] = (lo_s[a] < 0) ? '0 : lo_s[a];
         hi_c[a] = (hi_s[a] > $signed(LIM_W'(grid_dim(a) - 1))) ?
                   $signed(LIM_W'(grid_dim(a) - 1)) : hi_s[a];
         if (lo_c[a] > hi_c[a]) begin
            empty = 1'b1;
         end
         if (idx_ff[a] < 0 || idx_ff[a] > $signed(IDX_W'(grid_dim(a) - 1))) begin
            in_grid = 1'b0;
         end
      end
      x_end = (cur_ff[0] == hi_ff[0]);
      y_end = (cur_ff[1] == hi_ff[1]);
      z_end = (cur_ff[2] == hi_ff[2]);
   end

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      diff_in    = diff_ff;
      axis_in    = axis_ff;
      idx_in     = idx_ff;
      k_in       = k_ff;
      acc_in     = acc_ff;
      r2_in      = r2_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      cur_in     = cur_ff;
      off_in     = off_ff;
      off0_in    = off0_ff;
      ax2_in     = ax2_ff;
      ay2_in     = ay2_ff;
      pv_in      = 1'b0;
      psum_in    = psum_ff;
      paz2_in    = paz2_ff;
      coll_in    = coll_ff;
      outside_in = outside_ff;
      idle       = 1'b0;
      occ        = '0;
      res        = '0;

      // second scan stage: check the word read last cycle
      if (pv_ff && occ_rd_data && (psum_ff + SUM_W'(paz2_ff) < SUM_W'(r2_ff))) begin
         coll_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            idle = 1'b1;
            if (start) begin
               func_in    = item.func;
               diff_in[0] = DIFF_W'(item.px) - DIFF_W'(cfg.origin_x);
               diff_in[1] = DIFF_W'(item.py) - DIFF_W'(cfg.origin_y);
               diff_in[2] = DIFF_W'(item.pz) - DIFF_W'(cfg.origin_z);
               axis_in    = '0;
               k_in       = '0;
               acc_in     = '0;
               r2_in      = SQ_W'(cfg.sphere_radius) * SQ_W'(cfg.sphere_radius);
               coll_in    = 1'b0;
               outside_in = 1'b0;
               state_in   = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_RND;
         end
         ST_RND: begin
            idx_in[axis_ff] = idx_new;
            if (axis_ff == 2'd2) begin
               state_in = (func_ff == FUNC_QUERY) ? ST_RADIUS : ST_INSERT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_INSERT: begin
            occ.wr_en  = in_grid;
            occ.addr   = cell_addr(idx_ff[0][C_W-1:0], idx_ff[1][C_W-1:0],
                                   idx_ff[2][C_W-1:0]);
            outside_in = !in_grid;
            state_in   = ST_DONE;
         end
         ST_RADIUS: begin
            // smallest k with k * edge >= radius, capped
            if (acc_ff >= ACC_W'(cfg.sphere_radius) ||
                k_ff == RV_W'(MAX_RADIUS_VOXELS)) begin
               state_in = ST_BOUND;
            end else begin
               acc_in = acc_ff + ACC_W'(cfg.voxel_edge);
               k_in   = k_ff + 1'b1;
            end
         end
         ST_BOUND: begin
            for (int a = 0; a < 3; a++) begin
               lo_in[a] = lo_c[a][C_W-1:0];
               hi_in[a] = hi_c[a][C_W-1:0];
            end
            state_in = empty ? ST_DONE : ST_OFFSET;
         end
         ST_OFFSET: begin
            for (int a = 0; a < 3; a++) begin
               off0_in[a] = OFF_W'(diff_ff[a]) - $signed(OFF_W'(lo_ff[a]) * ve_ext);
            end
            off_in[0] = OFF_W'(diff_ff[0]) - $signed(OFF_W'(lo_ff[0]) * ve_ext);
            cur_in[0] = lo_ff[0];
            state_in  = ST_XROW;
         end
         ST_XROW: begin
            if (coll_ff) begin
               state_in = ST_DONE;
            end else if (ok[0]) begin
               ax2_in    = sq;
               cur_in[1] = lo_ff[1];
               off_in[1] = off0_ff[1];
               state_in  = ST_YROW;
            end else if (!x_end) begin
               cur_in[0] = cur_ff[0] + 1'b1;
               off_in[0] = off_ff[0] - $signed(ve_ext);
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_YROW: begin
            if (coll_ff) begin
               state_in = ST_DONE;
            end else if (ok[1]) begin
               ay2_in    = sq;
               cur_in[2] = lo_ff[2];
               off_in[2] = off0_ff[2];
               state_in  = ST_ZSCAN;
            end else if (!y_end) begin
               cur_in[1] = cur_ff[1] + 1'b1;
               off_in[1] = off_ff[1] - $signed(ve_ext);
            end else if (!x_end) begin
               cur_in[0] = cur_ff[0] + 1'b1;
               off_in[0] = off_ff[0] - $signed(ve_ext);
               state_in  = ST_XROW;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_ZSCAN: begin
            if (coll_ff) begin
               state_in = ST_DONE;
            end else begin
               // issue one grid read per cycle
               occ.rd_en = ok[2];
               occ.addr  = cell_addr(cur_ff[0], cur_ff[1], cur_ff[2]);
               pv_in     = ok[2];
               psum_in   = SUM_W'(ax2_ff) + SUM_W'(ay2_ff);
               paz2_in   = sq;
               if (!z_end) begin
                  cur_in[2] = cur_ff[2] + 1'b1;
                  off_in[2] = off_ff[2] - $signed(ve_ext);
               end else if (!y_end) begin
                  cur_in[1] = cur_ff[1] + 1'b1;
                  off_in[1] = off_ff[1] - $signed(ve_ext);
                  state_in  = ST_YROW;
               end else if (!x_end) begin
                  cur_in[0] = cur_ff[0] + 1'b1;
                  off_in[0] = off_ff[0] - $signed(ve_ext);
                  state_in  = ST_XROW;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            res.valid        = 1'b1;
            res.collision    = coll_ff;
            res.outside_grid = outside_ff;
            if (take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         pv_ff    <= pv_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      diff_ff    <= diff_in;
      axis_ff    <= axis_in;
      prod_ff    <= prod_in;
      idx_ff     <= idx_in;
      k_ff       <= k_in;
      acc_ff     <= acc_in;
      r2_ff      <= r2_in;
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      cur_ff     <= cur_in;
      off_ff     <= off_in;
      off0_ff    <= off0_in;
      ax2_ff     <= ax2_in;
      ay2_ff     <= ay2_in;
      psum_ff    <= psum_in;
      paz2_ff    <= paz2_in;
      coll_ff    <= coll_in;
      outside_ff <= outside_in;
   end

endmodule

### hw/rtl/vgsc_checker.sv
// Port-level checks of the voxel grid sphere collision block, bound to its top level.
// Depends on vgsc_pkg for the result word type.
module vgsc_checker
   import vgsc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // hold a stalled result word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // grid sweep follows reset, so no word is taken right after it
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("input accepted during grid sweep");

   a_flag_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.collision && rsp_data.outside_grid))
      else $error("collision and outside flags both set");

   a_collision_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.collision |-> rsp_data.query_count != 32'd0)
      else $error("collision reported with zero query count");

endmodule

bind voxel_grid_sphere_collision vgsc_checker u_vgsc_checker (.*);
